// ===== sv/bqdf2t_pkg.sv =====
// types, constants and control program for the transposed direct form ii biquad
package bqdf2t_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int COEF_BITS = 32;
	localparam int INT_BITS = 48;
	localparam int INT_FRAC = 40;
	localparam int ACC_BITS = INT_BITS + 2;
	localparam int HALF_BITS = INT_BITS / 2;
	localparam int PP_BITS = HALF_BITS + COEF_BITS;
	localparam int PROD_BITS = INT_BITS + COEF_BITS;
	localparam int NUM_COEFS = 5;
	localparam int CFG_IDX_BITS = 3;
	localparam int STEP_BITS = 4;

	// shifts for coefficient reset values given in q2.30
	localparam int COEF_SHL = (COEF_BITS >= 32) ? COEF_BITS - 32 : 0;
	localparam int COEF_SHR = (COEF_BITS < 32) ? 32 - COEF_BITS : 0;

	localparam logic signed [31:0] COEF_RESET_Q30 [NUM_COEFS] = '{
		32'sd129324, 32'sd258650, 32'sd129325, -32'sd2039238329, 32'sd969349503
	};

	typedef enum logic [CFG_IDX_BITS-1:0] {
		COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2
	} coef_sel_t;

	typedef enum logic {OPND_X, OPND_Y} opnd_t;
	typedef enum logic {HALF_LO, HALF_HI} half_t;
	typedef enum logic [1:0] {PROD_HOLD, PROD_LOAD, PROD_ADD_HI} prod_op_t;
	typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_D1, BASE_D2} base_t;
	typedef enum logic [1:0] {DEST_NONE, DEST_Y, DEST_D1, DEST_D2} dest_t;
	typedef enum logic [1:0] {OUT_NONE, OUT_FILTER, OUT_ZERO} out_sel_t;
	typedef enum logic [1:0] {JUMP_NEXT, JUMP_ITEM, JUMP_RESULT} jump_t;

	localparam logic [STEP_BITS-1:0] STEP_IDLE = STEP_BITS'(0);
	localparam logic [STEP_BITS-1:0] STEP_RESULT = STEP_BITS'(14);
	localparam logic [STEP_BITS-1:0] STEP_CLEAR = STEP_BITS'(15);

	typedef struct packed {
		opnd_t                  opnd;
		half_t                  half;
		coef_sel_t              coef;
		prod_op_t               prod_op;
		base_t                  base;
		logic                   term_sub;
		logic                   acc_we;
		dest_t                  dest;
		logic                   clr_state;
		out_sel_t               out_sel;
		jump_t                  jump;
		logic [STEP_BITS-1:0]   target;
	} ucode_t;

	typedef struct packed {
		logic                          command;
		logic signed [SAMPLE_BITS-1:0] sample_in;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          clipped;
	} result_t;

	function automatic logic signed [COEF_BITS-1:0] coef_reset(input int idx);
		logic signed [63:0] v;
		v = 64'(COEF_RESET_Q30[idx]);
		if (COEF_BITS >= 32) begin
			v = v <<< COEF_SHL;
		end else begin
			v = v >>> COEF_SHR;
		end
		return v[COEF_BITS-1:0];
	endfunction

	// control program: each product takes a lo and a hi half pass on the shared multiplier
	function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
		ucode_t w;
		w = '{opnd: OPND_X, half: HALF_LO, coef: COEF_B0, prod_op: PROD_HOLD,
			base: BASE_ZERO, term_sub: 1'b0, acc_we: 1'b0, dest: DEST_NONE,
			clr_state: 1'b0, out_sel: OUT_NONE, jump: JUMP_NEXT, target: STEP_IDLE};
		case (step)
			STEP_BITS'(0): begin
				w.jump = JUMP_ITEM;
				w.target = STEP_CLEAR;
			end
			STEP_BITS'(1): begin
				w.coef = COEF_B0;
			end
			STEP_BITS'(2): begin
				w.coef = COEF_B0;
				w.half = HALF_HI;
				w.prod_op = PROD_LOAD;
			end
			STEP_BITS'(3): begin
				w.coef = COEF_B1;
				w.prod_op = PROD_ADD_HI;
			end
			STEP_BITS'(4): begin
				w.coef = COEF_B1;
				w.half = HALF_HI;
				w.prod_op = PROD_LOAD;
			end
			STEP_BITS'(5): begin
				// y = b0*x + z1
				w.coef = COEF_B2;
				w.prod_op = PROD_ADD_HI;
				w.base = BASE_D1;
				w.dest = DEST_Y;
			end
			STEP_BITS'(6): begin
				w.coef = COEF_B2;
				w.half = HALF_HI;
				w.prod_op = PROD_LOAD;
			end
			STEP_BITS'(7): begin
				// partial z1 = b1*x + z2, old z2 consumed here
				w.opnd = OPND_Y;
				w.coef = COEF_A1;
				w.prod_op = PROD_ADD_HI;
				w.base = BASE_D2;
				w.acc_we = 1'b1;
			end
			STEP_BITS'(8): begin
				w.opnd = OPND_Y;
				w.coef = COEF_A1;
				w.half = HALF_HI;
				w.prod_op = PROD_LOAD;
			end
			STEP_BITS'(9): begin
				// z2 register holds b2*x for now
				w.opnd = OPND_Y;
				w.coef = COEF_A2;
				w.prod_op = PROD_ADD_HI;
				w.dest = DEST_D2;
			end
			STEP_BITS'(10): begin
				w.opnd = OPND_Y;
				w.coef = COEF_A2;
				w.half = HALF_HI;
				w.prod_op = PROD_LOAD;
			end
			STEP_BITS'(11): begin
				w.prod_op = PROD_ADD_HI;
				w.base = BASE_ACC;
				w.term_sub = 1'b1;
				w.dest = DEST_D1;
			end
			STEP_BITS'(12): begin
				w.jump = JUMP_NEXT;
			end
			STEP_BITS'(13): begin
				w.base = BASE_D2;
				w.term_sub = 1'b1;
				w.dest = DEST_D2;
			end
			STEP_RESULT: begin
				w.out_sel = OUT_FILTER;
				w.jump = JUMP_RESULT;
				w.target = STEP_IDLE;
			end
			STEP_CLEAR: begin
				w.clr_state = 1'b1;
				w.out_sel = OUT_ZERO;
				w.jump = JUMP_RESULT;
				w.target = STEP_IDLE;
			end
			default: begin
				w.jump = JUMP_NEXT;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/biquad_iir_filter_df2t.sv =====
// biquad iir section, transposed direct form ii, microcoded over one shared multiplier
//
// item channel: item_valid/item_stall with item (command, sample_in in q1.23).
// result channel: result_valid/result_stall with result (sample_out, clipped).
// cfg channel: cfg_valid/cfg_ready, cfg_index selects b0, b1, b2, a1, a2 (q2.30);
// cfg_ready is always high, unknown indexes are dropped.
// a filter item runs 15 of the 16 program steps: five products of a 48-bit state
// value and a coefficient, each split into two 24-bit halves on one multiplier.
// the result is registered at the result step, and the next item can be taken once
// the program is back at the idle step, so a new item is not taken before the last
// one is through; a clear item jumps to the clear step and returns zero.
// item_stall is high while the program runs. the result register is filled
// at the last step; if the receiver stalls a previous result the program
// waits on that step until the register is free.
// reset loads the default low-pass coefficients, zeroes both state registers
// and empties the result register.
module biquad_iir_filter_df2t (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  bqdf2t_pkg::item_t                   item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output bqdf2t_pkg::result_t                 result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bqdf2t_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bqdf2t_pkg::COEF_BITS-1:0]    cfg_data
);

	localparam int SB = bqdf2t_pkg::SAMPLE_BITS;
	localparam int CB = bqdf2t_pkg::COEF_BITS;
	localparam int IB = bqdf2t_pkg::INT_BITS;
	localparam int AB = bqdf2t_pkg::ACC_BITS;
	localparam int HB = bqdf2t_pkg::HALF_BITS;
	localparam int PPB = bqdf2t_pkg::PP_BITS;
	localparam int PB = bqdf2t_pkg::PROD_BITS;
	localparam int OSH = bqdf2t_pkg::INT_FRAC - (SB - 1);
	localparam int RSH = CB - 2;
	localparam int QW = PB - RSH + 1;
	localparam int RW = IB + 1 - OSH;

	localparam logic [PB:0] RND_HALF = (PB + 1)'(1) << (RSH - 1);
	localparam logic [QW-1:0] MAG_POS_MAX = (QW'(1) << (IB - 1)) - QW'(1);
	localparam logic [QW-1:0] MAG_NEG_MAX = QW'(1) << (IB - 1);
	localparam logic signed [IB-1:0] INT_MAX = {1'b0, {(IB - 1){1'b1}}};
	localparam logic signed [IB-1:0] INT_MIN = {1'b1, {(IB - 1){1'b0}}};
	localparam logic [IB:0] OUT_HALF = (IB + 1)'(1) << (OSH - 1);
	localparam logic signed [SB-1:0] SMP_MAX = {1'b0, {(SB - 1){1'b1}}};
	localparam logic signed [SB-1:0] SMP_MIN = {1'b1, {(SB - 1){1'b0}}};

	logic [bqdf2t_pkg::STEP_BITS-1:0] pc_q;
	logic [bqdf2t_pkg::STEP_BITS-1:0] pc_nxt;
	bqdf2t_pkg::ucode_t               uw;

	logic signed [CB-1:0] coef_q [bqdf2t_pkg::NUM_COEFS];
	logic signed [SB-1:0] sample_q;
	logic signed [IB-1:0] y_q;
	logic signed [IB-1:0] d1_q;
	logic signed [IB-1:0] d2_q;
	logic signed [AB-1:0] acc_q;
	logic [PPB-1:0]       pp_s1;
	logic                 neg_s1;
	logic [PB-1:0]        prod_q;
	logic                 prod_neg_q;
	logic signed [IB-1:0] term_q;
	logic                 res_valid_q;
	bqdf2t_pkg::result_t  res_q;

	logic                 item_accept;
	logic                 out_free;
	logic                 out_load;
	logic signed [IB-1:0] x40;
	logic signed [IB-1:0] opnd_a;
	logic [IB-1:0]        mag_a;
	logic [HB-1:0]        half_a;
	logic signed [CB-1:0] coef_v;
	logic [CB-1:0]        mag_b;
	logic [PB:0]          rnd_sum;
	logic [QW-1:0]        rnd_mag;
	logic [QW-1:0]        mag_lim;
	logic [IB-1:0]        mag_sat;
	logic signed [IB-1:0] term_nxt;
	logic signed [AB-1:0] base_v;
	logic signed [AB-1:0] term_ext;
	logic signed [AB-1:0] acc_nxt;
	logic [AB-IB:0]       acc_top;
	logic signed [IB-1:0] acc_sat;
	logic [IB:0]          y_rnd;
	logic [RW-1:0]        r_val;
	logic [RW-SB:0]       r_top;
	logic                 r_clip;
	bqdf2t_pkg::result_t  res_nxt;

	assign uw = bqdf2t_pkg::ucode_rom(pc_q);

	assign item_stall = (pc_q != bqdf2t_pkg::STEP_IDLE);
	assign item_accept = item_valid && !item_stall;
	assign out_free = !res_valid_q || !result_stall;
	assign out_load = (uw.out_sel != bqdf2t_pkg::OUT_NONE) && out_free;
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign result = res_q;

	// step counter with conditional jumps
	always_comb begin
		pc_nxt = pc_q + bqdf2t_pkg::STEP_BITS'(1);
		case (uw.jump)
			bqdf2t_pkg::JUMP_ITEM: begin
				if (!item_accept) begin
					pc_nxt = pc_q;
				end else if (item.command) begin
					pc_nxt = uw.target;
				end
			end
			bqdf2t_pkg::JUMP_RESULT: begin
				pc_nxt = out_free ? uw.target : pc_q;
			end
			default: begin
				pc_nxt = pc_q + bqdf2t_pkg::STEP_BITS'(1);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bqdf2t_pkg::STEP_IDLE;
		end else begin
			pc_q <= pc_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bqdf2t_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= bqdf2t_pkg::coef_reset(i);
			end
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bqdf2t_pkg::COEF_B0: coef_q[bqdf2t_pkg::COEF_B0] <= cfg_data;
				bqdf2t_pkg::COEF_B1: coef_q[bqdf2t_pkg::COEF_B1] <= cfg_data;
				bqdf2t_pkg::COEF_B2: coef_q[bqdf2t_pkg::COEF_B2] <= cfg_data;
				bqdf2t_pkg::COEF_A1: coef_q[bqdf2t_pkg::COEF_A1] <= cfg_data;
				bqdf2t_pkg::COEF_A2: coef_q[bqdf2t_pkg::COEF_A2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			sample_q <= item.sample_in;
		end
	end

	// operands as sign and magnitude, product rounded half away from zero
	always_comb begin
		x40 = {{(IB - SB){sample_q[SB-1]}}, sample_q} << OSH;
		opnd_a = (uw.opnd == bqdf2t_pkg::OPND_Y) ? y_q : x40;
		mag_a = opnd_a[IB-1] ? -opnd_a : opnd_a;
		half_a = (uw.half == bqdf2t_pkg::HALF_HI) ? mag_a[IB-1:HB] : mag_a[HB-1:0];
		coef_v = coef_q[uw.coef];
		mag_b = coef_v[CB-1] ? -coef_v : coef_v;
	end

	always_ff @(posedge clk) begin
		pp_s1 <= {{CB{1'b0}}, half_a} * {{HB{1'b0}}, mag_b};
		neg_s1 <= opnd_a[IB-1] ^ coef_v[CB-1];
	end

	always_ff @(posedge clk) begin
		case (uw.prod_op)
			bqdf2t_pkg::PROD_LOAD: begin
				prod_q <= {{(PB - PPB){1'b0}}, pp_s1};
				prod_neg_q <= neg_s1;
			end
			bqdf2t_pkg::PROD_ADD_HI: begin
				prod_q <= prod_q + {pp_s1, {HB{1'b0}}};
			end
			default: ;
		endcase
	end

	always_comb begin
		rnd_sum = {1'b0, prod_q} + RND_HALF;
		rnd_mag = rnd_sum[PB:RSH];
		mag_lim = prod_neg_q ? MAG_NEG_MAX : MAG_POS_MAX;
		mag_sat = (rnd_mag > mag_lim) ? mag_lim[IB-1:0] : rnd_mag[IB-1:0];
		term_nxt = prod_neg_q ? -mag_sat : mag_sat;
	end

	always_ff @(posedge clk) begin
		term_q <= term_nxt;
	end

	// accumulator: base plus or minus the rounded term, saturated when written to y, d1 or d2
	always_comb begin
		case (uw.base)
			bqdf2t_pkg::BASE_ACC: base_v = acc_q;
			bqdf2t_pkg::BASE_D1:  base_v = AB'(d1_q);
			bqdf2t_pkg::BASE_D2:  base_v = AB'(d2_q);
			default:              base_v = '0;
		endcase
		term_ext = AB'(term_q);
		acc_nxt = uw.term_sub ? base_v - term_ext : base_v + term_ext;
		acc_top = acc_nxt[AB-1:IB-1];
		if ((&acc_top) || !(|acc_top)) begin
			acc_sat = acc_nxt[IB-1:0];
		end else begin
			acc_sat = acc_nxt[AB-1] ? INT_MIN : INT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (uw.acc_we) begin
			acc_q <= acc_nxt;
		end
		if (uw.dest == bqdf2t_pkg::DEST_Y) begin
			y_q <= acc_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else if (uw.clr_state) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			case (uw.dest)
				bqdf2t_pkg::DEST_D1: d1_q <= acc_sat;
				bqdf2t_pkg::DEST_D2: d2_q <= acc_sat;
				default: ;
			endcase
		end
	end

	// output rounding half up to the sample format, then saturation
	always_comb begin
		y_rnd = {y_q[IB-1], y_q} + OUT_HALF;
		r_val = y_rnd[IB:OSH];
		r_top = r_val[RW-1:SB-1];
		r_clip = !((&r_top) || !(|r_top));
		res_nxt = '0;
		if (uw.out_sel == bqdf2t_pkg::OUT_FILTER) begin
			res_nxt.clipped = r_clip;
			if (r_clip) begin
				res_nxt.sample_out = r_val[RW-1] ? SMP_MIN : SMP_MAX;
			end else begin
				res_nxt.sample_out = r_val[SB-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_nxt;
		end
	end

`ifndef SYNTH
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_accept |=> item_stall)
		else $error("item taken while the program was running");

	a_wait_for_result_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == bqdf2t_pkg::STEP_RESULT && res_valid_q && result_stall)
		|=> pc_q == bqdf2t_pkg::STEP_RESULT)
		else $error("program left the result step while the result was stalled");

	a_clear_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && uw.out_sel == bqdf2t_pkg::OUT_ZERO)
		|=> (res_q.sample_out == '0 && !res_q.clipped))
		else $error("clear item did not return zero");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.clipped)
		|-> (res_q.sample_out == SMP_MAX || res_q.sample_out == SMP_MIN))
		else $error("clipped flag set on a sample inside the range");
`endif

endmodule

// ===== dv/tb_biquad_iir_filter_df2t.sv =====
// self-checking testbench for the transposed direct form ii biquad section
module tb_biquad_iir_filter_df2t;

	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;
	localparam int SMP_BITS = bqdf2t_pkg::SAMPLE_BITS;
	localparam int CF_BITS = bqdf2t_pkg::COEF_BITS;
	localparam int N_COEFS = bqdf2t_pkg::NUM_COEFS;
	localparam int IDX_BITS = bqdf2t_pkg::CFG_IDX_BITS;
	localparam int SHIFT_OUT = bqdf2t_pkg::INT_FRAC - (SMP_BITS - 1);
	localparam int SHIFT_COEF = CF_BITS - 2;
	localparam longint STATE_MAX = (longint'(1) <<< (bqdf2t_pkg::INT_BITS - 1)) - 1;
	localparam longint STATE_MIN = -STATE_MAX - 1;
	localparam longint PCM_MAX = (longint'(1) <<< (SMP_BITS - 1)) - 1;
	localparam longint PCM_MIN = -PCM_MAX - 1;
	localparam logic [CF_BITS-1:0] COEF_POS_MAX = {1'b0, {(CF_BITS-1){1'b1}}};
	localparam logic [CF_BITS-1:0] COEF_NEG_MAX = {1'b1, {(CF_BITS-1){1'b0}}};
	localparam logic [CF_BITS-1:0] COEF_ONE = CF_BITS'(1) << (CF_BITS - 2);
	localparam logic [CF_BITS-1:0] COEF_MINUS_ONE = -COEF_ONE;
	localparam logic [CF_BITS-1:0] LOWPASS [N_COEFS] = '{
		32'sd129324, 32'sd258650, 32'sd129325, -32'sd2039238329, 32'sd969349503
	};
	localparam int HOLD_CYCLES = 400;
	localparam int SEG_ITEMS = 200;
	localparam int NUM_SEGS = 8;

	class biquad_scoreboard;
		longint coef [N_COEFS];
		longint delay_one;
		longint delay_two;
		bqdf2t_pkg::result_t expected_q [$];
		int errors;

		function new();
			for (int i = 0; i < N_COEFS; i++) begin
				coef[i] = longint'(signed'(LOWPASS[i]));
			end
			delay_one = 0;
			delay_two = 0;
			errors = 0;
		endfunction

		function void set_coef(bqdf2t_pkg::coef_sel_t sel, logic [CF_BITS-1:0] data);
			if (int'(sel) < N_COEFS) begin
				coef[int'(sel)] = longint'(signed'(data));
			end
		endfunction

		// q8.40 times q2.30, rounded half away from zero, saturated to the state width
		function longint scaled_product(longint a, longint b);
			logic [127:0] mag;
			longint lim;
			bit neg;
			neg = (a < 0) != (b < 0);
			mag = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
			mag = (mag + (128'(1) << (SHIFT_COEF - 1))) >> SHIFT_COEF;
			lim = neg ? -STATE_MIN : STATE_MAX;
			if (mag > 128'(lim)) begin
				mag = 128'(lim);
			end
			return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
		endfunction

		function longint clamp_state(longint v);
			if (v > STATE_MAX) begin
				return STATE_MAX;
			end
			if (v < STATE_MIN) begin
				return STATE_MIN;
			end
			return v;
		endfunction

		function void note_item(bqdf2t_pkg::item_t it);
			longint x40, y, z1, z2, r;
			bqdf2t_pkg::result_t want;
			want = '0;
			if (it.command == CMD_CLEAR) begin
				delay_one = 0;
				delay_two = 0;
				expected_q.push_back(want);
				return;
			end
			x40 = longint'(signed'(it.sample_in)) <<< SHIFT_OUT;
			y = clamp_state(scaled_product(x40, coef[bqdf2t_pkg::COEF_B0]) + delay_one);
			z1 = scaled_product(x40, coef[bqdf2t_pkg::COEF_B1])
				- scaled_product(y, coef[bqdf2t_pkg::COEF_A1]) + delay_two;
			z2 = scaled_product(x40, coef[bqdf2t_pkg::COEF_B2])
				- scaled_product(y, coef[bqdf2t_pkg::COEF_A2]);
			delay_one = clamp_state(z1);
			delay_two = clamp_state(z2);
			// round half up to the sample grid, then clip
			r = (y + (longint'(1) <<< (SHIFT_OUT - 1))) >>> SHIFT_OUT;
			if (r > PCM_MAX) begin
				r = PCM_MAX;
				want.clipped = 1'b1;
			end else if (r < PCM_MIN) begin
				r = PCM_MIN;
				want.clipped = 1'b1;
			end
			want.sample_out = r[SMP_BITS-1:0];
			expected_q.push_back(want);
		endfunction

		task report(string msg);
			if (errors < 64) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
			errors++;
		endtask

		task check_result(bqdf2t_pkg::result_t got);
			bqdf2t_pkg::result_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result sample_out=%0d clipped=%0b",
					got.sample_out, got.clipped));
				return;
			end
			want = expected_q.pop_front();
			if (got.sample_out !== want.sample_out) begin
				report($sformatf("sample_out got %0d want %0d",
					got.sample_out, want.sample_out));
			end
			if (got.clipped !== want.clipped) begin
				report($sformatf("clipped got %0b want %0b (sample_out %0d)",
					got.clipped, want.clipped, want.sample_out));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	bqdf2t_pkg::item_t item;
	logic result_valid;
	logic result_stall = 1'b0;
	bqdf2t_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [IDX_BITS-1:0] cfg_index;
	logic [CF_BITS-1:0] cfg_data;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_go = 1'b0;
	logic rx_hold = 1'b0;
	biquad_scoreboard sb;

	biquad_iir_filter_df2t dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// receiver: checks accepted results and decides the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			sb.check_result(result);
		end
		if (rx_hold) begin
			result_stall <= 1'b1;
		end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// long receiver hold-off so the result register fills and the input backs up
	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic bqdf2t_pkg::item_t pcm(logic cmd, longint v);
		bqdf2t_pkg::item_t it;
		it.command = cmd;
		it.sample_in = v[SMP_BITS-1:0];
		return it;
	endfunction

	function automatic bqdf2t_pkg::item_t random_item();
		int pick;
		bqdf2t_pkg::item_t it;
		pick = $urandom_range(99);
		it.command = CMD_FILTER;
		it.sample_in = SMP_BITS'($urandom);
		if (pick < 3) begin
			it.command = CMD_CLEAR;
		end else if (pick < 18) begin
			case ($urandom_range(4))
				0: it = pcm(CMD_FILTER, PCM_MAX);
				1: it = pcm(CMD_FILTER, PCM_MIN);
				2: it = pcm(CMD_FILTER, 0);
				3: it = pcm(CMD_FILTER, 1);
				default: it = pcm(CMD_FILTER, -1);
			endcase
		end else if (pick < 40) begin
			it.sample_in = signed'(SMP_BITS'($urandom)) >>> $urandom_range(4, 20);
		end
		return it;
	endfunction

	function automatic logic [CF_BITS-1:0] random_coef(int style);
		case (style)
			1: return CF_BITS'(signed'($urandom) >>> $urandom_range(2, 10));
			2: return CF_BITS'($urandom);
			default: begin
				case ($urandom_range(3))
					0: return COEF_POS_MAX;
					1: return COEF_NEG_MAX;
					2: return '0;
					default: return CF_BITS'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic send(bqdf2t_pkg::item_t it);
		if (tx_idle_pct != 0) begin
			while ($urandom_range(99) < tx_idle_pct) begin
				item_valid <= 1'b0;
				@(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		sb.note_item(it);
	endtask

	// every item returns one result, so an empty queue means the block is idle
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_coefs(input logic [CF_BITS-1:0] vals [N_COEFS]);
		bqdf2t_pkg::coef_sel_t sel;
		for (int i = 0; i < N_COEFS; i++) begin
			sel = bqdf2t_pkg::coef_sel_t'(i);
			cfg_valid <= 1'b1;
			cfg_index <= sel;
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_coef(sel, vals[i]);
		end
		// an index past the last coefficient must be dropped
		cfg_index <= IDX_BITS'($urandom_range(N_COEFS, (1 << IDX_BITS) - 1));
		cfg_data <= CF_BITS'($urandom);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int tx_pct, int rx_pct);
		tx_idle_pct <= tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	initial begin
		logic [CF_BITS-1:0] coefs [N_COEFS];
		int style;
		sb = new();
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(9, 86);
		@(posedge clk);

		// default low-pass: clear ignoring its sample, impulse, negative step, bit patterns
		send(pcm(CMD_CLEAR, PCM_MAX));
		send(pcm(CMD_FILTER, PCM_MAX));
		send(pcm(CMD_FILTER, 0));
		send(pcm(CMD_FILTER, 0));
		repeat (3) send(pcm(CMD_FILTER, PCM_MIN));
		send(pcm(CMD_FILTER, 1));
		send(pcm(CMD_FILTER, -1));
		send(pcm(CMD_FILTER, 24'h555555));
		send(pcm(CMD_FILTER, 24'hAAAAAA));
		send(pcm(CMD_CLEAR, 24'h555555));
		drain();

		// coefficient extremes drive the internal state into saturation
		coefs = '{COEF_POS_MAX, COEF_POS_MAX, COEF_POS_MAX, COEF_NEG_MAX, COEF_NEG_MAX};
		write_coefs(coefs);
		send(pcm(CMD_FILTER, PCM_MAX));
		send(pcm(CMD_FILTER, PCM_MAX));
		send(pcm(CMD_FILTER, PCM_MIN));
		send(pcm(CMD_FILTER, PCM_MIN));
		drain();
		coefs = '{COEF_NEG_MAX, COEF_NEG_MAX, COEF_NEG_MAX, COEF_POS_MAX, COEF_POS_MAX};
		write_coefs(coefs);
		send(pcm(CMD_FILTER, PCM_MAX));
		send(pcm(CMD_FILTER, PCM_MIN));
		send(pcm(CMD_CLEAR, 0));
		drain();

		// unity gain passes the sample through, negative unity clips the most negative one
		coefs = '{COEF_ONE, '0, '0, '0, '0};
		write_coefs(coefs);
		send(pcm(CMD_FILTER, PCM_MIN));
		send(pcm(CMD_FILTER, PCM_MAX));
		drain();
		coefs = '{COEF_MINUS_ONE, '0, '0, '0, '0};
		write_coefs(coefs);
		send(pcm(CMD_FILTER, PCM_MIN));
		send(pcm(CMD_FILTER, PCM_MAX));
		drain();

		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			if (seg < 3) begin
				set_idling(9, 86);
			end else if (seg < 6) begin
				set_idling(86, 9);
			end else begin
				set_idling(0, 0);
			end
			style = seg % 4;
			for (int i = 0; i < N_COEFS; i++) begin
				coefs[i] = (style == 0) ? LOWPASS[i] : random_coef(style);
			end
			write_coefs(coefs);
			for (int n = 0; n < SEG_ITEMS; n++) begin
				if (seg == 6 && n == 10) begin
					hold_go <= 1'b1;
				end
				send(random_item());
			end
			drain();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
